@@ rtl/core/c128_pkg.sv @@
// Shared types, constants and the symbol width table for the Code 128 encoder.
// No dependencies.
package c128_pkg;

  localparam int RUN_MAX_DEF = 32;

  localparam logic [6:0] SYM_START_B = 7'd104;
  localparam logic [6:0] SYM_CODE_C  = 7'd99;
  localparam logic [6:0] SYM_CODE_B  = 7'd100;
  localparam logic [6:0] SYM_CODE_A  = 7'd101;
  localparam logic [6:0] SYM_STOP    = 7'd106;
  localparam logic [6:0] MOD_VAL     = 7'd103;

  typedef enum logic [1:0] {
    SET_A = 2'd0,
    SET_B = 2'd1,
    SET_C = 2'd2
  } cset_t;

  // Symbol source selected by the controller.
  typedef enum logic [2:0] {
    SRC_CONST = 3'd0,  // constant symbol value in cmd
    SRC_PAIR  = 3'd1,  // two buffered digits
    SRC_DIGIT = 3'd2,  // one buffered digit in set B
    SRC_CHAR  = 3'd3,  // current character
    SRC_SUM   = 3'd4   // checksum
  } src_t;

  typedef struct packed {
    logic       emit;      // put a symbol on the output register
    logic       weighted;  // add to checksum
    src_t       src;
    logic [6:0] const_sym;
    logic       last;      // last symbol of this request
    logic       rd_adv1;   // advance read pointer by one
    logic       rd_adv2;   // advance read pointer by two
    logic       rd_rst;    // return read pointer to the top of the buffer
    logic       start;     // restart checksum at Start B
    logic       clr_msg;   // clear checksum at end of message
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;   // output register holds an unaccepted request
  } dp_sts_t;

  // Widths packed as seven 3-bit fields, first bar in the top field.
  function automatic logic [20:0] sym_widths(input logic [6:0] v);
    logic [20:0] w;
    logic [23:0] d;
    case (v)
      7'd0: d=24'h212222; 7'd1: d=24'h222122; 7'd2: d=24'h222221; 7'd3: d=24'h121223;
      7'd4: d=24'h121322; 7'd5: d=24'h131222; 7'd6: d=24'h122213; 7'd7: d=24'h122312;
      7'd8: d=24'h132212; 7'd9: d=24'h221213; 7'd10: d=24'h221312; 7'd11: d=24'h231212;
      7'd12: d=24'h112232; 7'd13: d=24'h122132; 7'd14: d=24'h122231; 7'd15: d=24'h113222;
      7'd16: d=24'h123122; 7'd17: d=24'h123221; 7'd18: d=24'h223211; 7'd19: d=24'h221132;
      7'd20: d=24'h221231; 7'd21: d=24'h213212; 7'd22: d=24'h223112; 7'd23: d=24'h312131;
      7'd24: d=24'h311222; 7'd25: d=24'h321122; 7'd26: d=24'h321221; 7'd27: d=24'h312212;
      7'd28: d=24'h322112; 7'd29: d=24'h322211; 7'd30: d=24'h212123; 7'd31: d=24'h212321;
      7'd32: d=24'h232121; 7'd33: d=24'h111323; 7'd34: d=24'h131123; 7'd35: d=24'h131321;
      7'd36: d=24'h112313; 7'd37: d=24'h132113; 7'd38: d=24'h132311; 7'd39: d=24'h211313;
      7'd40: d=24'h231113; 7'd41: d=24'h231311; 7'd42: d=24'h112133; 7'd43: d=24'h112331;
      7'd44: d=24'h132131; 7'd45: d=24'h113123; 7'd46: d=24'h113321; 7'd47: d=24'h133121;
      7'd48: d=24'h313121; 7'd49: d=24'h211331; 7'd50: d=24'h231131; 7'd51: d=24'h213113;
      7'd52: d=24'h213311; 7'd53: d=24'h213131; 7'd54: d=24'h311123; 7'd55: d=24'h311321;
      7'd56: d=24'h331121; 7'd57: d=24'h312113; 7'd58: d=24'h312311; 7'd59: d=24'h332111;
      7'd60: d=24'h314111; 7'd61: d=24'h221411; 7'd62: d=24'h431111; 7'd63: d=24'h111224;
      7'd64: d=24'h111422; 7'd65: d=24'h121124; 7'd66: d=24'h121421; 7'd67: d=24'h141122;
      7'd68: d=24'h141221; 7'd69: d=24'h112214; 7'd70: d=24'h112412; 7'd71: d=24'h122114;
      7'd72: d=24'h122411; 7'd73: d=24'h142112; 7'd74: d=24'h142211; 7'd75: d=24'h241211;
      7'd76: d=24'h221114; 7'd77: d=24'h413111; 7'd78: d=24'h241112; 7'd79: d=24'h134111;
      7'd80: d=24'h111242; 7'd81: d=24'h121142; 7'd82: d=24'h121241; 7'd83: d=24'h114212;
      7'd84: d=24'h124112; 7'd85: d=24'h124211; 7'd86: d=24'h411212; 7'd87: d=24'h421112;
      7'd88: d=24'h421211; 7'd89: d=24'h212141; 7'd90: d=24'h214121; 7'd91: d=24'h412121;
      7'd92: d=24'h111143; 7'd93: d=24'h111341; 7'd94: d=24'h131141; 7'd95: d=24'h114113;
      7'd96: d=24'h114311; 7'd97: d=24'h411113; 7'd98: d=24'h411311; 7'd99: d=24'h113141;
      7'd100: d=24'h114131; 7'd101: d=24'h311141; 7'd102: d=24'h411131; 7'd103: d=24'h211412;
      7'd104: d=24'h211214; 7'd105: d=24'h211232;
      default: d=24'h0;
    endcase
    // Six-element symbols: hex digits map to 3-bit fields, seventh is zero.
    w = {d[22:20], d[18:16], d[14:12], d[10:8], d[6:4], d[2:0], 3'd0};
    if (v == SYM_STOP) begin
      w = {3'd2, 3'd3, 3'd3, 3'd1, 3'd1, 3'd1, 3'd2};
    end
    return w;
  endfunction

endpackage

@@ rtl/core/code128_symbol_encoder_core.sv @@
// Channel  | Ports                                                  | Direction
// in       | in_valid in_stall in_char_code in_end_of_message       | request in
// out      | out_valid out_stall out_symbol_value out_width_1..7    | symbols out
//          | out_last_of_run out_run_overflow                       |
// One symbol leaves per cycle while the controller emits and the output is
// not stalled. A request is accepted, loaded, then emits its symbols; each
// run flush (even an empty one) ends in a closing step, and a code switch that
// is not needed still takes a check step. A digit in mid-message emits nothing.
// Synchronous active-low reset; the buffer needs no clearing pass.
// Output stalls hold the controller in its current emitting step.
// Depends on c128_pkg, c128_ctrl and c128_datapath.
module code128_symbol_encoder_core import c128_pkg::*; #(
  parameter int RUN_MAX = RUN_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [6:0] in_char_code,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_symbol_value,
  output logic [2:0] out_width_1,
  output logic [2:0] out_width_2,
  output logic [2:0] out_width_3,
  output logic [2:0] out_width_4,
  output logic [2:0] out_width_5,
  output logic [2:0] out_width_6,
  output logic [2:0] out_width_7,
  output logic       out_last_of_run,
  output logic       out_run_overflow
);

  localparam int PW = $clog2(RUN_MAX);

  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic [3:0]    wr_digit;
  logic [6:0]    cur_char;
  logic          ovf;
  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [20:0]   widths;

  c128_ctrl #(.RUN_MAX(RUN_MAX)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_char_code, .in_end_of_message,
    .wr_en, .wr_addr, .wr_digit, .cur_char, .ovf, .cmd, .sts
  );

  c128_datapath #(.RUN_MAX(RUN_MAX)) u_dp (
    .clk, .rst_n, .wr_en, .wr_addr, .wr_digit, .cur_char, .ovf, .cmd, .sts,
    .out_valid, .out_stall, .out_symbol_value, .out_widths(widths),
    .out_last_of_run, .out_run_overflow
  );

  assign out_width_1 = widths[20:18];
  assign out_width_2 = widths[17:15];
  assign out_width_3 = widths[14:12];
  assign out_width_4 = widths[11:9];
  assign out_width_5 = widths[8:6];
  assign out_width_6 = widths[5:3];
  assign out_width_7 = widths[2:0];

endmodule

@@ rtl/core/c128_datapath.sv @@
// Datapath: digit buffer, checksum, symbol formation and output register.
// Depends on c128_pkg.
module c128_datapath import c128_pkg::*; #(
  parameter int RUN_MAX = RUN_MAX_DEF,
  localparam int PW = $clog2(RUN_MAX)
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [PW-1:0] wr_addr,
  input  logic [3:0] wr_digit,
  input  logic [6:0] cur_char,
  input  logic       ovf,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_symbol_value,
  output logic [20:0] out_widths,
  output logic       out_last_of_run,
  output logic       out_run_overflow
);

  logic [3:0] mem [RUN_MAX];
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0] rd_ptr_p1;
  logic [3:0] d0_r, d1_r;
  logic [6:0] sum_r, sum_nxt;
  logic [6:0] wpos_r, wpos_nxt;
  logic [6:0] sym;
  logic       load;
  logic [13:0] prod_r;
  logic        pend_r, pend_nxt;
  logic [27:0] recip;
  logic [6:0]  quo;
  logic [13:0] rem14;
  logic [7:0] acc;
  logic [6:0] acc_mod;
  logic       ov_r, ov_nxt;
  logic [6:0] sym_r;
  logic       last_r;
  logic       ovo_r;

  assign load      = cmd.emit && !sts.out_busy;
  assign rd_ptr_p1 = PW'(rd_ptr_nxt + 1'b1);

  // Buffer write, registered reads at the read pointer and the next entry.
  // A digit written in the same cycle is forwarded to the read registers.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_digit;
    end
    d0_r <= (wr_en && wr_addr == rd_ptr_nxt) ? wr_digit : mem[rd_ptr_nxt];
    d1_r <= (wr_en && wr_addr == rd_ptr_p1) ? wr_digit : mem[rd_ptr_p1];
  end

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    if (load) begin
      if (cmd.rd_adv1) rd_ptr_nxt = PW'(rd_ptr_r + 1'b1);
      if (cmd.rd_adv2) rd_ptr_nxt = PW'(rd_ptr_r + 2'd2);
    end
    if (cmd.start || cmd.rd_rst) rd_ptr_nxt = '0;
  end

  // Symbol source selection.
  always_comb begin
    case (cmd.src)
      SRC_PAIR:  sym = 7'(d0_r) * 7'd10 + 7'(d1_r);
      SRC_DIGIT: sym = 7'(d0_r) + 7'd16;
      SRC_CHAR:  sym = (cur_char <= 7'd31) ? cur_char + 7'd64 : cur_char - 7'd32;
      SRC_SUM:   sym = sum_r;
      default:   sym = cmd.const_sym;
    endcase
  end

  // Checksum second stage: the registered product is reduced mod 103 with a
  // reciprocal scaled by 2^20, exact for products below 13184, then folded
  // into the running sum with one compare and subtract.
  always_comb begin
    recip   = 28'(prod_r) * 28'd10181;
    quo     = recip[26:20];
    rem14   = prod_r - 14'(quo) * 14'(MOD_VAL);
    acc     = {1'b0, sum_r} + {1'b0, rem14[6:0]};
    acc_mod = (acc >= {1'b0, MOD_VAL}) ? 7'(acc - {1'b0, MOD_VAL}) : acc[6:0];
  end

  assign sts.out_busy = ov_r && out_stall;

  // Next values of the output flag, checksum and weight.
  always_comb begin
    ov_nxt   = ov_r && out_stall;
    sum_nxt  = pend_r ? acc_mod : sum_r;
    wpos_nxt = wpos_r;
    pend_nxt = 1'b0;
    if (load) begin
      ov_nxt = 1'b1;
      if (cmd.weighted) begin
        pend_nxt = 1'b1;
        wpos_nxt = (wpos_r == 7'd102) ? 7'd0 : wpos_r + 7'd1;
      end
    end
    if (cmd.start) begin
      sum_nxt  = 7'd1;
      wpos_nxt = 7'd1;
      pend_nxt = 1'b0;
    end
    if (cmd.clr_msg) begin
      sum_nxt  = '0;
      wpos_nxt = '0;
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r     <= 1'b0;
      rd_ptr_r <= '0;
      sum_r    <= '0;
      wpos_r   <= '0;
      pend_r   <= 1'b0;
    end else begin
      ov_r     <= ov_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      sum_r    <= sum_nxt;
      wpos_r   <= wpos_nxt;
      pend_r   <= pend_nxt;
    end
  end

  // Output payload and the first checksum stage, the weighted product.
  always_ff @(posedge clk) begin
    if (load) begin
      sym_r  <= sym;
      last_r <= cmd.last;
      ovo_r  <= ovf;
      if (cmd.weighted) begin
        prod_r <= 14'(sym) * 14'(wpos_r);
      end
    end
  end

  assign out_valid        = ov_r;
  assign out_symbol_value = sym_r;
  assign out_widths       = sym_widths(sym_r);
  assign out_last_of_run  = last_r;
  assign out_run_overflow = ovo_r;

endmodule

@@ rtl/core/c128_ctrl.sv @@
// Controller: sequences the symbols of each request.
// Depends on c128_pkg.
module c128_ctrl import c128_pkg::*; #(
  parameter int RUN_MAX = RUN_MAX_DEF,
  localparam int PW = $clog2(RUN_MAX),
  localparam int LW = $clog2(RUN_MAX + 1)
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [6:0] in_char_code,
  input  logic       in_end_of_message,
  output logic       wr_en,
  output logic [PW-1:0] wr_addr,
  output logic [3:0] wr_digit,
  output logic [6:0] cur_char,
  output logic       ovf,
  output dp_cmd_t    cmd,
  input  dp_sts_t    sts
);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_LOAD, S_FLUSH, S_SWITCH, S_CHAR, S_SUM, S_STOP
  } state_t;

  state_t state_r, state_nxt;
  logic [6:0] char_r, char_nxt;
  logic       eom_r, eom_nxt;
  logic       inmsg_r, inmsg_nxt;
  logic       ovf_r, ovf_nxt;
  cset_t      set_r, set_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] rem_r, rem_nxt;
  logic       lp_r, lp_nxt;   // flushing the final run of the message
  logic       isdig, isctl, acc_in, go, need_sw, tail_last;

  assign isdig  = (char_r >= 7'd48) && (char_r <= 7'd57);
  assign isctl  = char_r <= 7'd31;
  assign acc_in = in_valid && !in_stall;
  assign go     = !sts.out_busy;
  assign in_stall = (state_r != S_IDLE);
  assign cur_char = char_r;
  assign ovf      = ovf_r;
  assign wr_addr  = len_r[PW-1:0];
  assign wr_digit = 4'(char_r - 7'd48);
  assign need_sw  = isctl ? (set_r != SET_A) : (set_r != SET_B);
  assign tail_last = !eom_r;

  always_comb begin
    state_nxt = state_r; char_nxt = char_r; eom_nxt = eom_r; inmsg_nxt = inmsg_r;
    ovf_nxt = ovf_r; set_nxt = set_r; len_nxt = len_r; rem_nxt = rem_r; lp_nxt = lp_r;
    wr_en = 1'b0;
    cmd = '0;
    cmd.src = SRC_CONST;
    case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          char_nxt = in_char_code;
          eom_nxt  = in_end_of_message;
          lp_nxt   = 1'b0;
          state_nxt = inmsg_r ? S_LOAD : S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        inmsg_nxt = 1'b1;
        set_nxt   = SET_B;
        len_nxt   = '0;
        cmd.emit  = 1'b1;
        cmd.const_sym = SYM_START_B;
        // A buffered digit that does not end the message adds nothing more.
        cmd.last  = isdig && !eom_r;
        if (go) state_nxt = S_LOAD;
        else cmd.start = 1'b0;
        if (!go) begin
          inmsg_nxt = inmsg_r; set_nxt = set_r; len_nxt = len_r;
        end
      end
      S_LOAD: begin
        // Digits go to the buffer while it has room; other characters flush the run first.
        if (isdig) begin
          if (len_r < LW'(RUN_MAX)) begin
            wr_en   = 1'b1;
            len_nxt = len_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (eom_r) begin
            lp_nxt = 1'b1;
            rem_nxt = (len_r < LW'(RUN_MAX)) ? len_r + 1'b1 : len_r;
            cmd.start = 1'b0;
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          rem_nxt = len_r;
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.emit = 1'b1;
        cmd.weighted = 1'b1;
        if (rem_r != '0) begin
          if (set_r != SET_C && rem_r >= LW'(4) && !rem_r[0]) begin
            cmd.const_sym = SYM_CODE_C;
            if (go) set_nxt = SET_C;
          end else if (set_r == SET_A) begin
            cmd.const_sym = SYM_CODE_B;
            if (go) set_nxt = SET_B;
          end else if (set_r == SET_C && rem_r >= LW'(2)) begin
            cmd.src = SRC_PAIR;
            cmd.rd_adv2 = 1'b1;
            if (go) rem_nxt = rem_r - LW'(2);
          end else begin
            cmd.src = SRC_DIGIT;
            cmd.rd_adv1 = 1'b1;
            if (go) begin
              rem_nxt = rem_r - 1'b1;
              set_nxt = SET_B;
            end
          end
        end else if (!lp_r && set_r == SET_C) begin
          cmd.const_sym = SYM_CODE_B;
          if (go) set_nxt = SET_B;
        end else begin
          cmd.emit = 1'b0;
          cmd.weighted = 1'b0;
          len_nxt = '0;
          cmd.rd_rst = 1'b1;
          state_nxt = lp_r ? S_SUM : S_SWITCH;
        end
      end
      S_SWITCH: begin
        if (need_sw) begin
          cmd.emit = 1'b1; cmd.weighted = 1'b1;
          cmd.const_sym = isctl ? SYM_CODE_A : SYM_CODE_B;
          if (go) begin
            set_nxt = isctl ? SET_A : SET_B;
            state_nxt = S_CHAR;
          end
        end else begin
          state_nxt = S_CHAR;
        end
      end
      S_CHAR: begin
        cmd.emit = 1'b1; cmd.weighted = 1'b1;
        cmd.src = SRC_CHAR;
        cmd.last = tail_last;
        if (go) begin
          if (eom_r) begin
            lp_nxt = 1'b1;
            rem_nxt = '0;
            state_nxt = S_FLUSH;
          end else begin
            ovf_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      S_SUM: begin
        cmd.emit = 1'b1;
        cmd.src = SRC_SUM;
        if (go) state_nxt = S_STOP;
      end
      S_STOP: begin
        cmd.emit = 1'b1;
        cmd.const_sym = SYM_STOP;
        cmd.last = 1'b1;
        if (go) begin
          cmd.clr_msg = 1'b1;
          inmsg_nxt = 1'b0;
          set_nxt = SET_B;
          len_nxt = '0;
          ovf_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The flush restarts the read pointer at the top of the run.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      inmsg_r <= 1'b0;
      ovf_r   <= 1'b0;
      set_r   <= SET_B;
      len_r   <= '0;
      rem_r   <= '0;
      lp_r    <= 1'b0;
      eom_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      inmsg_r <= inmsg_nxt;
      ovf_r   <= ovf_nxt;
      set_r   <= set_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      lp_r    <= lp_nxt;
      eom_r   <= eom_nxt;
    end
    char_r <= char_nxt;
  end

  // Run length never exceeds the buffer and the remaining count fits in it.
  assert property (@(posedge clk) disable iff (!rst_n) len_r <= LW'(RUN_MAX))
    else $error("run length beyond buffer");
  assert property (@(posedge clk) disable iff (!rst_n) rem_r <= LW'(RUN_MAX))
    else $error("remaining count beyond buffer");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STOP && go) |=> (state_r == S_IDLE && !inmsg_r))
    else $error("message not closed after stop");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for code128_symbol_encoder_core: drives characters,
// predicts the Code 128 symbol stream and checks every output symbol.
// Depends on c128_pkg and the encoder RTL.
module testbench import c128_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT = RUN_MAX_DEF;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [6:0] ch;
    logic       eom;
  } char_req_t;

  typedef struct packed {
    logic [6:0]  sym;
    logic [20:0] widths;
    logic        last;
    logic        ovf;
  } sym_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [6:0] in_char_code = '0;
  logic in_end_of_message = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [6:0] out_symbol_value;
  logic [2:0] out_width_1, out_width_2, out_width_3, out_width_4;
  logic [2:0] out_width_5, out_width_6, out_width_7;
  logic out_last_of_run, out_run_overflow;

  code128_symbol_encoder_core dut (.*);

  // Encoder state mirrored by the predictor.
  logic [3:0] digits[RUN_LIMIT];
  int         run_len;
  cset_t      cur_set;
  int         csum;
  int         weight;
  bit         msg_open;
  bit         dropped;

  char_req_t pending_chars[$];
  sym_res_t  expected_syms[$];
  sym_res_t  item_syms[$];
  int mismatches, syms_seen, chars_sent, quiet_cycles;
  bit quiet_mode, stim_done;

  initial forever #10 clk = ~clk;

  // Symbol table widths: six elements plus a stop bar for the stop symbol.
  function automatic logic [20:0] widths_of(int v);
    int tbl[107] = '{
      212222,222122,222221,121223,121322,131222,122213,122312,
      132212,221213,221312,231212,112232,122132,122231,113222,
      123122,123221,223211,221132,221231,213212,223112,312131,
      311222,321122,321221,312212,322112,322211,212123,212321,
      232121,111323,131123,131321,112313,132113,132311,211313,
      231113,231311,112133,112331,132131,113123,113321,133121,
      313121,211331,231131,213113,213311,213131,311123,311321,
      331121,312113,312311,332111,314111,221411,431111,111224,
      111422,121124,121421,141122,141221,112214,112412,122114,
      122411,142112,142211,241211,221114,413111,241112,134111,
      111242,121142,121241,114212,124112,124211,411212,421112,
      421211,212141,214121,412121,111143,111341,131141,114113,
      114311,411113,411311,113141,114131,311141,411131,211412,
      211214,211232,2331112};
    int p, dv;
    logic [20:0] w;
    p = tbl[v];
    dv = (v == 106) ? 1000000 : 100000;
    for (int k = 0; k < 7; k++) begin
      w[20-3*k -: 3] = (dv == 0) ? 3'd0 : 3'((p / dv) % 10);
      dv = dv / 10;
    end
    return w;
  endfunction

  task automatic add_sym(int v);
    sym_res_t r;
    r.sym = 7'(v);
    r.widths = widths_of(v);
    r.last = 1'b0;
    r.ovf = 1'b0;
    item_syms = {item_syms, r};
  endtask

  task automatic add_weighted(int v);
    add_sym(v);
    csum = (csum + v * weight) % 103;
    weight = (weight + 1) % 103;
  endtask

  // Emit buffered digits, using set C whenever an even count of four or more remains.
  task automatic flush_digits(bit followed);
    int i, rem;
    i = 0;
    while (i < run_len) begin
      rem = run_len - i;
      if (cur_set != SET_C && rem >= 4 && rem % 2 == 0) begin
        add_weighted(SYM_CODE_C);
        cur_set = SET_C;
      end else if (cur_set == SET_A) begin
        add_weighted(SYM_CODE_B);
        cur_set = SET_B;
      end else if (cur_set == SET_C && rem >= 2) begin
        add_weighted(digits[i] * 10 + digits[i+1]);
        i += 2;
      end else begin
        if (cur_set == SET_C) cur_set = SET_B;
        add_weighted(digits[i] + 16);
        i++;
      end
    end
    if (followed && cur_set == SET_C) begin
      add_weighted(SYM_CODE_B);
      cur_set = SET_B;
    end
    run_len = 0;
  endtask

  // Work out the symbols one accepted character request causes.
  task automatic encode_char(char_req_t rq);
    int c;
    c = rq.ch;
    item_syms.delete();
    if (!msg_open) begin
      msg_open = 1;
      cur_set = SET_B;
      run_len = 0;
      add_sym(SYM_START_B);
      csum = 1;
      weight = 1;
    end
    if (c >= 48 && c <= 57) begin
      if (run_len < RUN_LIMIT) begin
        digits[run_len] = 4'(c - 48);
        run_len++;
      end else begin
        dropped = 1;
      end
    end else begin
      flush_digits(1);
      if (c <= 31) begin
        if (cur_set != SET_A) begin
          add_weighted(SYM_CODE_A);
          cur_set = SET_A;
        end
        add_weighted(c + 64);
      end else begin
        if (cur_set != SET_B) begin
          add_weighted(SYM_CODE_B);
          cur_set = SET_B;
        end
        add_weighted(c - 32);
      end
    end
    if (rq.eom) begin
      flush_digits(0);
      add_sym(csum % 103);
      add_sym(SYM_STOP);
      msg_open = 0;
      cur_set = SET_B;
      csum = 0;
      weight = 0;
      run_len = 0;
    end
    if (item_syms.size() > 0) begin
      item_syms[item_syms.size()-1].last = 1'b1;
      foreach (item_syms[k]) begin
        item_syms[k].ovf = dropped;
        expected_syms = {expected_syms, item_syms[k]};
      end
      dropped = 0;
    end
  endtask

  task automatic queue_char(int c, bit e);
    char_req_t rq;
    rq.ch = 7'(c);
    rq.eom = e;
    pending_chars = {pending_chars, rq};
  endtask

  function automatic int rand_digit();
    return 48 + $urandom_range(0, 9);
  endfunction

  function automatic int rand_char();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 31);
      1: return rand_digit();
      default: return $urandom_range(32, 127);
    endcase
  endfunction

  // Stimulus: directed messages, then random ones built around digit runs.
  initial begin
    int n, k;
    // Extremes, sets A/B/C, DEL, and a lone end-of-message character.
    queue_char(0, 0); queue_char(127, 0); queue_char(31, 0); queue_char(32, 1);
    queue_char(49, 0); queue_char(50, 0); queue_char(51, 0); queue_char(52, 0);
    queue_char(65, 0); queue_char(1, 0); queue_char(57, 0); queue_char(48, 1);
    queue_char(126, 1);
    // Even digit run ending the message, no trailing code switch.
    for (k = 0; k < 4; k++) queue_char(rand_digit(), k == 3);
    // Overflowing digit run followed by a letter.
    for (k = 0; k < RUN_LIMIT + 3; k++) queue_char(rand_digit(), 0);
    queue_char(90, 1);
    // Random messages.
    n = 0;
    while (n < 267) begin
      int len;
      len = $urandom_range(1, 14);
      for (k = 0; k < len; k++) begin
        int c;
        if ($urandom_range(0, 9) < 4) begin
          int rl;
          rl = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36)
                                             : $urandom_range(1, 8);
          for (int j = 0; j < rl; j++) begin
            queue_char(rand_digit(), 0);
            n++;
          end
        end
        c = rand_char();
        queue_char(c, k == len - 1);
        n++;
      end
    end
  end

  // Reset, then request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) chars_sent <= chars_sent + 1;
      if (pending_chars.size() > 0 && (quiet_mode || $urandom_range(0, 99) >= 15)) begin
        char_req_t rq;
        rq = pending_chars.pop_front();
        in_valid <= 1'b1;
        in_char_code <= rq.ch;
        in_end_of_message <= rq.eom;
      end else begin
        in_valid <= 1'b0;
        if (pending_chars.size() == 0) stim_done <= 1'b1;
      end
    end
  end

  // Predict on acceptance; randomize output stall; check symbols.
  always @(posedge clk) begin
    if (rst_n) begin
      char_req_t rq;
      sym_res_t got, exp_r;
      if (in_valid && !in_stall) begin
        rq.ch = in_char_code;
        rq.eom = in_end_of_message;
        encode_char(rq);
      end
      if (out_valid && !out_stall) begin
        syms_seen <= syms_seen + 1;
        got.sym = out_symbol_value;
        got.widths = {out_width_1, out_width_2, out_width_3, out_width_4,
                      out_width_5, out_width_6, out_width_7};
        got.last = out_last_of_run;
        got.ovf = out_run_overflow;
        if (expected_syms.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected symbol %0d", got.sym);
        end else begin
          exp_r = expected_syms.pop_front();
          if (got !== exp_r) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp %0d w=%h l=%b o=%b, got %0d w=%h l=%b o=%b",
                       exp_r.sym, exp_r.widths, exp_r.last, exp_r.ovf,
                       got.sym, got.widths, got.last, got.ovf);
          end
        end
      end
      out_stall <= quiet_mode ? 1'b0 : ($urandom_range(0, 99) < 15);
      quiet_mode <= (syms_seen > 200 && syms_seen < 450);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reset sequence, watchdog and final verdict.
  initial begin
    mismatches = 0; syms_seen = 0; chars_sent = 0; quiet_cycles = 0;
    quiet_mode = 0; stim_done = 0;
    run_len = 0; cur_set = SET_B; csum = 0; weight = 0; msg_open = 0; dropped = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (!(stim_done && !in_valid && expected_syms.size() == 0)
           && quiet_cycles < STALL_LIMIT)
      @(posedge clk);
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress, %0d symbols still expected", expected_syms.size());
      $display("testbench failed");
      $finish;
    end else begin
      repeat (50) @(posedge clk);
      $display("Sent %0d characters and checked %0d symbols, incl. overflowing digit runs.",
               chars_sent, syms_seen);
      if (mismatches == 0 && expected_syms.size() == 0) begin
        $display("testbench passed");
      end else begin
        $display("%0d mismatches", mismatches);
        $display("testbench failed");
      end
      $finish;
    end
  end

endmodule

@@ sim.f @@
rtl/core/c128_pkg.sv
rtl/core/c128_datapath.sv
rtl/core/c128_ctrl.sv
rtl/core/code128_symbol_encoder_core.sv
tb/testbench.sv
